FILE: hw/rtl/crlb_pkg.sv
`timescale 1ns / 1ps
package crlb_pkg;
  localparam int unsigned DepthDefault = 1024;
  localparam int unsigned CapW = 11;
  localparam int unsigned DataW = 32;
  localparam int unsigned PaddrW = 4;

  localparam logic [1:0] ModeWrite  = 2'd0;
  localparam logic [1:0] ModeRead   = 2'd1;
  localparam logic [1:0] ModeVerify = 2'd2;
  localparam logic [1:0] ModeClear  = 2'd3;

  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeHalf = 2'd1;
  localparam logic [1:0] SizeWord = 2'd2;

  localparam logic [PaddrW-1:0] AddrCapacity = 4'h0;
  localparam logic [PaddrW-1:0] AddrWordSize = 4'h4;
  localparam logic [PaddrW-1:0] AddrVersion  = 4'h8;

  function automatic logic [DataW-1:0] width_mask(input logic [1:0] code);
    logic [DataW-1:0] m;
    m = '1;
    if (code == SizeByte) m = 32'h0000_00ff;
    else if (code == SizeHalf) m = 32'h0000_ffff;
    return m;
  endfunction

  function automatic logic [1:0] eff_code(input logic [1:0] code);
    return (code >= SizeWord) ? SizeWord : code;
  endfunction
endpackage

FILE: hw/rtl/crlb_ram.sv
`timescale 1ns / 1ps
module crlb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: hw/rtl/crlb_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit a cycle; remainder only.
module crlb_divider import crlb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [31:0]     dividend_i,
  input  logic [CapW-1:0] divisor_i,
  output logic            done_o,
  output logic [CapW-1:0] rem_o
);
  logic [31:0]     quo_q;
  logic [CapW:0]   rem_q;
  logic [CapW-1:0] div_q;
  logic [5:0]      cnt_q;
  logic            busy_q;
  logic [CapW:0]   shifted;
  logic [CapW:0]   diff;

  assign shifted = {rem_q[CapW-1:0], quo_q[31]};
  assign diff    = shifted - {1'b0, div_q};
  assign rem_o   = rem_q[CapW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[30:0], 1'b0};
      rem_q <= diff[CapW] ? shifted : diff;
    end
  end
endmodule

FILE: hw/rtl/checksummed_ring_log_buffer.sv
`timescale 1ns / 1ps
// Write/read: the ring index is a remainder from the divider, followed by RAM access.
// Verify: sums the store up to capacity, one store word summed per cycle.
// Clear: all DEPTH entries are swept, one entry zeroed per cycle.
// One transaction at a time; result held in an output register until taken.
// Async active-low reset; the store is swept to zero after reset.
module checksummed_ring_log_buffer import crlb_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic [31:0]       word_i,
  input  logic [31:0]       offset_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       read_word_o,
  output logic [CapW-1:0]   length_o,
  output logic              is_valid_o,
  output logic [CapW-1:0]   stored_capacity_o,
  output logic [31:0]       stored_version_o
);
  typedef enum logic [2:0] {
    StInit, StIdle, StDiv, StAcc, StData, StSum, StClear, StOut
  } state_e;

  state_e          state_q;
  logic [CapW-1:0] cfg_cap_q;
  logic [1:0]      cfg_code_q;
  logic [31:0]     cfg_ver_q;
  logic [31:0]     head_q, sum_q, vsum_q, ver_q, word_q;
  logic [CapW-1:0] lcap_q;
  logic [1:0]      lcode_q, mode_q;
  logic [CapW:0]   idx_q;
  logic            rd_pend_q;

  logic [CapW-1:0] cap;
  logic [31:0]     mask, tail, dividend, rdm;
  logic            div_start, div_done;
  logic [CapW-1:0] rem;
  logic            we;
  logic [AW-1:0]   addr;
  logic [31:0]     wdata, rdata;
  logic            cfg_wr;

  assign cap = (cfg_cap_q == '0) ? CapW'(1) :
               ({21'd0, cfg_cap_q} > DEPTH) ? CapW'(DEPTH) : cfg_cap_q;
  assign mask = width_mask(cfg_code_q);
  assign tail = (head_q > {21'd0, cap}) ? head_q : 32'd0;
  assign dividend = (mode_i == ModeWrite) ? head_q : tail + offset_i;
  assign rdm = rdata & mask;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    unique case (paddr)
      AddrCapacity: prdata = {21'd0, cfg_cap_q};
      AddrWordSize: prdata = {30'd0, cfg_code_q};
      AddrVersion:  prdata = cfg_ver_q;
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cap_q  <= CapW'(1024);
      cfg_code_q <= SizeWord;
      cfg_ver_q  <= '0;
    end else if (cfg_wr) begin
      if (paddr == AddrCapacity) cfg_cap_q <= pwdata[CapW-1:0];
      if (paddr == AddrWordSize) cfg_code_q <= pwdata[1:0];
      if (paddr == AddrVersion) cfg_ver_q <= pwdata;
    end
  end

  assign in_stall_o = (state_q != StIdle);
  assign div_start = in_valid_i && !in_stall_o &&
                     (mode_i == ModeWrite || mode_i == ModeRead);

  crlb_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dividend),
    .divisor_i(cap), .done_o(div_done), .rem_o(rem)
  );

  always_comb begin
    we = 1'b0;
    addr = idx_q[AW-1:0];
    wdata = '0;
    if (state_q == StInit || state_q == StClear) we = 1'b1;
    else if (state_q == StAcc) addr = rem[AW-1:0];
    else if (state_q == StData && mode_q == ModeWrite) begin
      we = 1'b1;
      addr = rem[AW-1:0];
      wdata = word_q & mask;
    end
  end

  crlb_ram #(.Width(32), .Depth(DEPTH)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      idx_q <= '0;
      head_q <= '0; sum_q <= '0; ver_q <= '0; lcap_q <= '0; lcode_q <= '0;
      out_valid_o <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      unique case (state_q)
        StInit, StClear: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == (CapW+1)'(DEPTH - 1)) begin
            idx_q <= '0;
            state_q <= (state_q == StInit) ? StIdle : StOut;
            out_valid_o <= (state_q == StClear);
          end
        end
        StIdle: if (in_valid_i) begin
          mode_q <= mode_i;
          word_q <= word_i;
          read_word_o <= '0;
          is_valid_o <= 1'b0;
          idx_q <= '0;
          vsum_q <= '0;
          rd_pend_q <= 1'b0;
          unique case (mode_i)
            ModeWrite, ModeRead: state_q <= StDiv;
            ModeVerify: state_q <= StSum;
            default: begin
              sum_q <= '0; head_q <= '0;
              ver_q <= cfg_ver_q; lcap_q <= cap; lcode_q <= eff_code(cfg_code_q);
              state_q <= StClear;
            end
          endcase
        end
        StDiv: if (div_done) state_q <= StAcc;
        StAcc: state_q <= StData;
        StData: begin
          if (mode_q == ModeWrite) begin
            sum_q <= sum_q + (word_q & mask) - rdm;
            head_q <= head_q + 32'd1;
          end else begin
            read_word_o <= rdm;
          end
          state_q <= StOut;
          out_valid_o <= 1'b1;
        end
        StSum: begin
          // RAM read data is registered, so it trails the address sweep
          if (rd_pend_q) vsum_q <= vsum_q + rdm;
          rd_pend_q <= (idx_q < {1'b0, cap});
          if (idx_q < {1'b0, cap}) idx_q <= idx_q + 1'b1;
          else if (!rd_pend_q) begin
            is_valid_o <= (ver_q == cfg_ver_q) && (lcap_q == cap) &&
                          (lcode_q == eff_code(cfg_code_q)) && (sum_q == vsum_q);
            state_q <= StOut;
            out_valid_o <= 1'b1;
          end
        end
        StOut: if (!out_stall_i) begin
          out_valid_o <= 1'b0;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign length_o = (head_q < {21'd0, cap}) ? head_q[CapW-1:0] : cap;
  assign stored_capacity_o = lcap_q;
  assign stored_version_o = ver_q;

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accepting while result pending");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == StDiv) else $error("divider done out of sequence");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
endmodule

FILE: test/tb_checksummed_ring_log_buffer.sv
`timescale 1ns / 1ps
module tb_checksummed_ring_log_buffer;
  import crlb_pkg::*;

  localparam int unsigned Depth = 1024;

  typedef struct packed {
    logic [31:0]     read_word;
    logic [CapW-1:0] length;
    logic            is_valid;
    logic [CapW-1:0] stored_capacity;
    logic [31:0]     stored_version;
  } log_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        mode_i;
  logic [31:0]       word_i;
  logic [31:0]       offset_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [31:0]       read_word_o;
  logic [CapW-1:0]   length_o;
  logic              is_valid_o;
  logic [CapW-1:0]   stored_capacity_o;
  logic [31:0]       stored_version_o;

  checksummed_ring_log_buffer u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .mode_i, .word_i, .offset_i,
    .out_valid_o, .out_stall_i, .read_word_o, .length_o, .is_valid_o,
    .stored_capacity_o, .stored_version_o
  );

  // shadow of the block: configuration and state
  logic [CapW-1:0] cfg_capacity;
  logic [1:0]      cfg_size;
  logic [31:0]     cfg_version;
  logic [31:0]     ring_head;
  logic [31:0]     ring_sum;
  logic [31:0]     kept_version;
  logic [CapW-1:0] kept_capacity;
  logic [1:0]      kept_size;
  logic [31:0]     ring_mem [Depth];

  log_result_t expected_results[$];
  int          mismatch_count;
  int          burst_left;
  int          hold_cycles;
  bit          stall_pattern_on;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #400ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [31:0] size_mask(input logic [1:0] code);
    case (code)
      SizeByte: return 32'h0000_00ff;
      SizeHalf: return 32'h0000_ffff;
      default:  return 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [31:0] used_capacity();
    if (cfg_capacity == 0) return 1;
    if (cfg_capacity > Depth) return Depth;
    return cfg_capacity;
  endfunction

  function automatic log_result_t apply_log_op(input logic [1:0] op, input logic [31:0] wd,
                                               input logic [31:0] ofs);
    log_result_t r;
    logic [31:0] cap;
    logic [31:0] mask;
    logic [31:0] idx;
    logic [31:0] tail;
    logic [31:0] sum;
    logic [1:0]  code;
    cap = used_capacity();
    mask = size_mask(cfg_size);
    code = (cfg_size >= SizeWord) ? SizeWord : cfg_size;
    r = '0;
    case (op)
      ModeWrite: begin
        idx = ring_head % cap;
        ring_sum = ring_sum + (wd & mask) - (ring_mem[idx] & mask);
        ring_mem[idx] = wd & mask;
        ring_head = ring_head + 1;
      end
      ModeRead: begin
        tail = (ring_head > cap) ? ring_head : 32'd0;
        idx = (tail + ofs) % cap;
        r.read_word = ring_mem[idx] & mask;
      end
      ModeVerify: begin
        sum = 0;
        for (int i = 0; i < cap; i++) sum += ring_mem[i] & mask;
        r.is_valid = (kept_version == cfg_version) && (kept_capacity == cap)
                     && (kept_size == code) && (ring_sum == sum);
      end
      default: begin
        ring_sum = 0;
        ring_head = 0;
        kept_version = cfg_version;
        kept_capacity = cap[CapW-1:0];
        kept_size = code;
        for (int i = 0; i < Depth; i++) ring_mem[i] = 0;
      end
    endcase
    r.length = (ring_head < cap) ? ring_head[CapW-1:0] : cap[CapW-1:0];
    r.stored_capacity = kept_capacity;
    r.stored_version = kept_version;
    return r;
  endfunction

  task automatic write_reg(input logic [PaddrW-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (addr)
      AddrCapacity: cfg_capacity = data[CapW-1:0];
      AddrWordSize: cfg_size = data[1:0];
      default:      cfg_version = data;
    endcase
  endtask

  // bursts with random gaps; valid stays high across back-to-back items
  task automatic send_op(input logic [1:0] op, input logic [31:0] wd, input logic [31:0] ofs);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
    in_valid_i <= 1'b1;
    mode_i <= op;
    word_i <= wd;
    offset_i <= ofs;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(apply_log_op(op, wd, ofs));
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    // extra wait after the last result; a clear ends its sweep before its result
    repeat (Depth + 50) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] cap, input logic [1:0] code,
                            input logic [31:0] ver);
    go_idle();
    write_reg(AddrCapacity, cap);
    write_reg(AddrWordSize, {30'd0, code});
    write_reg(AddrVersion, ver);
  endtask

  task automatic test_directed();
    set_config(4, SizeWord, 32'hdead_beef);
    send_op(ModeVerify, 0, 0);
    send_op(ModeClear, 0, 0);
    send_op(ModeVerify, 0, 0);
    send_op(ModeWrite, 32'hffff_ffff, 0);
    send_op(ModeWrite, 32'h0000_0000, 0);
    send_op(ModeWrite, 32'h8000_0001, 0);
    send_op(ModeWrite, 32'h1234_5678, 0);
    send_op(ModeWrite, 32'haaaa_5555, 0);
    send_op(ModeRead, 0, 32'hffff_ffff);
    send_op(ModeRead, 0, 32'h0000_0003);
    send_op(ModeRead, 0, 32'h7fff_fffe);
    send_op(ModeVerify, 0, 0);
    // size code changes without a clear: code 3 acts as word, byte masks apply, verify flags it
    set_config(4, 2'd3, 32'hdead_beef);
    send_op(ModeVerify, 0, 0);
    send_op(ModeRead, 0, 1);
    set_config(4, SizeByte, 32'hdead_beef);
    send_op(ModeRead, 0, 2);
    send_op(ModeVerify, 0, 0);
    send_op(ModeClear, 0, 0);
    send_op(ModeWrite, 32'hffff_ff81, 0);
    send_op(ModeVerify, 0, 0);
    // capacity zero behaves as one, oversized as full depth
    set_config(0, SizeHalf, 0);
    send_op(ModeClear, 0, 0);
    send_op(ModeWrite, 32'h0001_ffff, 0);
    send_op(ModeWrite, 32'h0000_0042, 0);
    send_op(ModeRead, 0, 32'hffff_ffff);
    send_op(ModeVerify, 0, 0);
    set_config(2047, SizeWord, 32'hffff_ffff);
    send_op(ModeClear, 0, 0);
    send_op(ModeVerify, 0, 0);
  endtask

  task automatic test_random_phases();
    logic [31:0] cap;
    logic [1:0]  code;
    int          pick;
    for (int phase = 0; phase < 24; phase++) begin
      case (phase % 6)
        0: cap = 1;
        1: cap = Depth;
        2: cap = $urandom_range(0, 2047);
        default: cap = $urandom_range(1, 24);
      endcase
      code = $urandom_range(0, 3);
      set_config(cap, code, $urandom());
      send_op(ModeClear, 0, 0);
      for (int n = 0; n < 60; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) send_op(ModeWrite, $urandom(), $urandom());
        else if (pick < 88) send_op(ModeRead, $urandom(),
                                    pick[0] ? $urandom() : $urandom_range(0, 40));
        else if (pick < 98 && (cap < 64 || pick < 90)) send_op(ModeVerify, $urandom(), $urandom());
        else send_op(ModeClear, $urandom(), $urandom());
      end
      // occasionally change a setting mid-log so verify reports a mismatch
      if (phase % 5 == 4) begin
        go_idle();
        write_reg(AddrVersion, $urandom());
        send_op(ModeVerify, 0, 0);
        send_op(ModeWrite, $urandom(), 0);
      end
    end
  endtask

  task automatic test_backpressure();
    set_config(8, SizeWord, 32'h0bad_cafe);
    send_op(ModeClear, 0, 0);
    hold_cycles = 400;
    for (int n = 0; n < 20; n++) send_op(n[0] ? ModeRead : ModeWrite, $urandom(), n);
  endtask

  // receiver: own stall pattern plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else if (stall_pattern_on) begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (($urandom_range(0, 199)) == 0) stall_pattern_on <= ~stall_pattern_on;
  end

  always @(posedge clk_i) begin
    log_result_t got;
    log_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{read_word_o, length_o, is_valid_o, stored_capacity_o, stored_version_o};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected transaction: got %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    mode_i = ModeWrite;
    word_i = '0;
    offset_i = '0;
    out_stall_i = 1'b0;
    stall_pattern_on = 1'b1;
    hold_cycles = 0;
    burst_left = 0;
    mismatch_count = 0;
    cfg_capacity = 1024;
    cfg_size = SizeWord;
    cfg_version = 0;
    ring_head = 0;
    ring_sum = 0;
    kept_version = 0;
    kept_capacity = 0;
    kept_size = 0;
    for (int i = 0; i < Depth; i++) ring_mem[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phases();
    test_backpressure();
    go_idle();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
